/* src/sha256c_pkg.sv */
// Shared types, constants, round table and helper functions of the SHA-256 compression block.
package sha256c_pkg;

	localparam int WORD_W      = 32;
	localparam int BLOCK_WORDS = 16;
	localparam int ROUNDS      = 64;
	localparam int NUM_IV      = 8;
	localparam int CNT_W       = $clog2(ROUNDS) + 1;
	localparam int WADDR_W     = $clog2(BLOCK_WORDS);
	localparam int IDX_W       = $clog2(NUM_IV);
	localparam int PADDR_W     = $clog2(NUM_IV) + 2;
	localparam int PDATA_W     = 32;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [WADDR_W-1:0] waddr_t;
	typedef logic [IDX_W-1:0]   idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic   load;
		waddr_t load_addr;
		word_t  load_word;
		logic   prime;
		logic   run;
		cnt_t   cnt;
	} sched_ctrl_t;

	typedef struct packed {
		logic load_iv;
		logic init;
		logic step;
		logic fold;
		idx_t out_idx;
	} round_ctrl_t;

	localparam word_t IV_RESET [NUM_IV] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

endpackage

/* src/sha256c_if.sv */
// Valid/ready channel interfaces for message words and digest words.
interface sha256c_in_if;
	logic                valid;
	logic                ready;
	sha256c_pkg::word_t  msg_word;
	logic                start_message;
	logic                end_message;

	modport source (output valid, output msg_word, output start_message, output end_message,
		input ready);
	modport sink (input valid, input msg_word, input start_message, input end_message,
		output ready);
endinterface

interface sha256c_out_if;
	logic                valid;
	logic                ready;
	sha256c_pkg::word_t  digest_word;
	sha256c_pkg::idx_t   word_index;
	logic                last;

	modport source (output valid, output digest_word, output word_index, output last,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last,
		output ready);
endinterface

/* src/sha256c_ram.sv */
// Generic RAM with one write port and two registered read ports.
module sha256c_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* src/sha256c_regs.sv */
// APB register file holding the eight initial hash words.
module sha256c_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sha256c_pkg::PADDR_W-1:0]    paddr,
	input  logic [sha256c_pkg::PDATA_W-1:0]    pwdata,
	output logic [sha256c_pkg::PDATA_W-1:0]    prdata,
	output logic                               pready,
	output sha256c_pkg::word_t                 iv [sha256c_pkg::NUM_IV]
);
	import sha256c_pkg::*;

	word_t iv_q [NUM_IV];
	idx_t  reg_idx;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = iv_q[reg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_IV; i++) begin
				iv_q[i] <= IV_RESET[i];
			end
		end else if (psel && penable && pwrite) begin
			iv_q[reg_idx] <= pwdata;
		end
	end

	assign iv = iv_q;

endmodule

/* src/sha256c_sched.sv */
// Message schedule: sixteen-word window in RAM, expansion and round constant add.
module sha256c_sched (
	input  logic                      clk,
	input  sha256c_pkg::sched_ctrl_t  ctrl,
	output sha256c_pkg::word_t        wk_s1
);
	import sha256c_pkg::*;

	word_t  rd_a;
	word_t  rd_b;
	word_t  w_new;
	word_t  part_q;
	word_t  wm1_q;
	cnt_t   next_rnd;
	waddr_t raddr_a;
	waddr_t raddr_b;
	logic   expand;
	logic   we;
	waddr_t waddr;
	word_t  wdata;

	assign next_rnd = ctrl.prime ? '0 : ctrl.cnt + cnt_t'(1);
	assign raddr_a  = (next_rnd < cnt_t'(BLOCK_WORDS)) ? next_rnd[WADDR_W-1:0]
		: next_rnd[WADDR_W-1:0] - waddr_t'(7);
	assign raddr_b  = next_rnd[WADDR_W-1:0] + waddr_t'(1);

	assign expand = ctrl.cnt >= cnt_t'(BLOCK_WORDS);
	assign w_new  = expand ? part_q + rd_a + small_sigma0(rd_b) : rd_a;

	assign we    = ctrl.load || (ctrl.run && expand);
	assign waddr = ctrl.load ? ctrl.load_addr : ctrl.cnt[WADDR_W-1:0];
	assign wdata = ctrl.load ? ctrl.load_word : w_new;

	sha256c_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BLOCK_WORDS)
	) u_window (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	// The term two rounds back and the oldest window word are summed in the prior round.
	always_ff @(posedge clk) begin
		if (ctrl.run) begin
			wm1_q  <= w_new;
			part_q <= small_sigma1(wm1_q) + rd_b;
			wk_s1  <= w_new + ROUND_K[ctrl.cnt[CNT_W-2:0]];
		end
	end

endmodule

/* src/sha256c_round.sv */
// Hash state, working variables and the SHA-256 round function.
module sha256c_round (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sha256c_pkg::round_ctrl_t  ctrl,
	input  sha256c_pkg::word_t        iv [sha256c_pkg::NUM_IV],
	input  sha256c_pkg::word_t        wk,
	output sha256c_pkg::word_t        digest_word
);
	import sha256c_pkg::*;

	word_t hash_q [NUM_IV];
	word_t work_q [NUM_IV];
	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1  = work_q[7] + big_sigma1(work_q[4]) + ch + wk;
	assign t2  = big_sigma0(work_q[0]) + maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_IV; i++) begin
				hash_q[i] <= '0;
			end
		end else if (ctrl.load_iv) begin
			hash_q <= iv;
		end else if (ctrl.fold) begin
			for (int i = 0; i < NUM_IV; i++) begin
				hash_q[i] <= hash_q[i] + work_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			work_q <= hash_q;
		end else if (ctrl.step) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	assign digest_word = hash_q[ctrl.out_idx];

endmodule

/* src/sha256_compression.sv */
// Top level of the SHA-256 compression block with streaming word input and digest output.
//
//  Channel     Dir  Transfer                    Payload
//  msg_in      in   msg_in.valid & ready        msg_word, start_message, end_message
//  digest_out  out  digest_out.valid & ready    digest_word, word_index, last
//  APB         in   psel & penable & pwrite     iv_0 .. iv_7 at byte address 4*i
//
// Sixteen words are taken at one per cycle while idle and msg_in.valid is high;
// the sixteenth starts a priming step, the rounds and a final step that adds the
// working variables into the hash state.
// The rounds are paced by the schedule RAM, read two words a cycle for the next round.
// Input is not taken during the rounds or while digest words are offered.
// Reset restores the initial values and clears the hash state; stalls on the digest
// channel hold the current word.
module sha256_compression (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sha256c_pkg::PADDR_W-1:0]  paddr,
	input  logic [sha256c_pkg::PDATA_W-1:0]  pwdata,
	output logic [sha256c_pkg::PDATA_W-1:0]  prdata,
	output logic                             pready,
	sha256c_in_if.sink                       msg_in,
	sha256c_out_if.source                    digest_out
);
	import sha256c_pkg::*;

	state_t      state_q;
	state_t      state_d;
	cnt_t        cnt_q;
	cnt_t        cnt_d;
	waddr_t      wc_q;
	waddr_t      wc_d;
	idx_t        oidx_q;
	idx_t        oidx_d;
	logic        end_q;
	logic        end_d;
	waddr_t      eff_wc;
	sched_ctrl_t sched_ctrl;
	round_ctrl_t round_ctrl;
	word_t       iv [NUM_IV];
	word_t       wk;

	sha256c_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.iv      (iv)
	);

	sha256c_sched u_sched (
		.clk   (clk),
		.ctrl  (sched_ctrl),
		.wk_s1 (wk)
	);

	sha256c_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (round_ctrl),
		.iv          (iv),
		.wk          (wk),
		.digest_word (digest_out.digest_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			wc_q    <= '0;
			oidx_q  <= '0;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			wc_q    <= wc_d;
			oidx_q  <= oidx_d;
			end_q   <= end_d;
		end
	end

	assign eff_wc = msg_in.start_message ? '0 : wc_q;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		wc_d       = wc_q;
		oidx_d     = oidx_q;
		end_d      = end_q;
		msg_in.ready     = 1'b0;
		digest_out.valid = 1'b0;

		sched_ctrl.load      = 1'b0;
		sched_ctrl.load_addr = eff_wc;
		sched_ctrl.load_word = msg_in.msg_word;
		sched_ctrl.prime     = 1'b0;
		sched_ctrl.run       = 1'b0;
		sched_ctrl.cnt       = cnt_q;

		round_ctrl.load_iv = 1'b0;
		round_ctrl.init    = 1'b0;
		round_ctrl.step    = 1'b0;
		round_ctrl.fold    = 1'b0;
		round_ctrl.out_idx = oidx_q;

		unique case (state_q)
			ST_IDLE: begin
				msg_in.ready = 1'b1;
				if (msg_in.valid) begin
					sched_ctrl.load    = 1'b1;
					round_ctrl.load_iv = msg_in.start_message;
					if (eff_wc == waddr_t'(BLOCK_WORDS - 1)) begin
						wc_d    = '0;
						end_d   = msg_in.end_message;
						state_d = ST_PRIME;
					end else begin
						wc_d = eff_wc + waddr_t'(1);
					end
				end
			end
			ST_PRIME: begin
				sched_ctrl.prime = 1'b1;
				round_ctrl.init  = 1'b1;
				cnt_d            = '0;
				state_d          = ST_ROUND;
			end
			ST_ROUND: begin
				sched_ctrl.run  = cnt_q < cnt_t'(ROUNDS);
				round_ctrl.step = cnt_q != '0;
				cnt_d           = cnt_q + cnt_t'(1);
				if (cnt_q == cnt_t'(ROUNDS)) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				round_ctrl.fold = 1'b1;
				oidx_d          = '0;
				state_d         = end_q ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				digest_out.valid = 1'b1;
				if (digest_out.ready) begin
					oidx_d = oidx_q + idx_t'(1);
					if (oidx_q == idx_t'(NUM_IV - 1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign digest_out.word_index = oidx_q;
	assign digest_out.last       = oidx_q == idx_t'(NUM_IV - 1);

endmodule
